[design/assert_macros.svh]
// Assertion macros for the keyword substitution cipher RTL.
// No dependencies; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

[design/kwsc_pkg.sv]
// Types and constants of the keyword substitution cipher.
// No dependencies; used by kwsc_front, kwsc_fifo, kwsc_back, the core and the testbench.
package kwsc_pkg;

    localparam int unsigned LETTERS = 26;
    localparam int unsigned IDX_W   = 5;

    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LA  = 8'h61;
    localparam logic [7:0] CHAR_LZ  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_KEY   = 3'd1,
        OP_FINAL = 3'd2,
        OP_ENC   = 3'd3,
        OP_DEC   = 3'd4
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             is_letter;
        logic [IDX_W-1:0] idx;
        logic [7:0]       ch;
    } t_cmd;

endpackage

[design/kwsc_in_if.sv]
// Request channel into the cipher: opcode and byte with valid/ready.
// No dependencies.
interface kwsc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] in_char;

    modport source (output valid, output opcode, output in_char, input ready);
    modport sink   (input valid, input opcode, input in_char, output ready);
endinterface

[design/kwsc_out_if.sv]
// Result channel out of the cipher: one byte with valid/ready.
// No dependencies.
interface kwsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;

    modport source (output valid, output out_char, input ready);
    modport sink   (input valid, input out_char, output ready);
endinterface

[design/kwsc_front.sv]
// Front end: accepts requests, decodes the opcode and classifies the byte.
// Depends on kwsc_pkg and kwsc_in_if.
module kwsc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kwsc_in_if.sink           i_in,
    input  logic              i_push_ready,
    output logic              o_push,
    output kwsc_pkg::t_cmd    o_cmd
);

    logic           r_valid;
    kwsc_pkg::t_cmd r_cmd;
    kwsc_pkg::t_cmd n_cmd;
    logic           n_keep;
    logic [7:0]     upper;
    logic [7:0]     probe;

    assign i_in.ready = !r_valid || i_push_ready;

    always_comb begin
        upper = i_in.in_char;
        if (i_in.in_char >= kwsc_pkg::CHAR_LA && i_in.in_char <= kwsc_pkg::CHAR_LZ) begin
            upper = i_in.in_char - kwsc_pkg::CASE_GAP;
        end
        n_cmd.op  = kwsc_pkg::t_op'(i_in.opcode);
        n_keep    = 1'b1;
        probe     = upper;
        unique case (kwsc_pkg::t_op'(i_in.opcode))
            kwsc_pkg::OP_START, kwsc_pkg::OP_FINAL, kwsc_pkg::OP_ENC: begin
                probe = upper;
            end
            kwsc_pkg::OP_KEY: begin
                probe = upper;
            end
            kwsc_pkg::OP_DEC: begin
                probe = i_in.in_char;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
        n_cmd.ch        = probe;
        n_cmd.is_letter = probe >= kwsc_pkg::CHAR_A && probe <= kwsc_pkg::CHAR_Z;
        n_cmd.idx       = kwsc_pkg::IDX_W'(probe - kwsc_pkg::CHAR_A);
        // drop key characters that are not letters
        if (kwsc_pkg::t_op'(i_in.opcode) == kwsc_pkg::OP_KEY && !n_cmd.is_letter) begin
            n_keep = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid && n_keep;
            r_cmd   <= n_cmd;
        end
    end

    assign o_push = r_valid;
    assign o_cmd  = r_cmd;

endmodule

[design/kwsc_fifo.sv]
// Short request queue between the front end and the back end.
// Depends on kwsc_pkg.
module kwsc_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kwsc_pkg::t_cmd    i_push_cmd,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output kwsc_pkg::t_cmd    o_pop_cmd,
    input  logic              i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    kwsc_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_push_ready = r_count != CW'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/kwsc_back.sv]
// Back end: holds the cipher tables, builds the key and substitutes text.
// Depends on kwsc_pkg, kwsc_out_if and assert_macros.svh.
`include "assert_macros.svh"

module kwsc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  kwsc_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    kwsc_out_if.source        o_out
);

    localparam int unsigned IW = kwsc_pkg::IDX_W;
    localparam int unsigned NL = kwsc_pkg::LETTERS;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state               r_state;
    logic [IW-1:0]        r_fwd [NL];
    logic [IW-1:0]        r_inv [NL];
    logic [NL-1:0]        r_used;
    logic [IW-1:0]        r_len;
    logic                 r_ready;
    logic [IW-1:0]        r_walk;
    logic                 r_ovalid;
    logic [7:0]           r_ochar;

    logic                 is_text;
    logic                 out_free;
    logic                 place_en;
    logic [IW-1:0]        place_idx;
    logic [7:0]           n_ochar;

    assign is_text  = i_cmd.op == kwsc_pkg::OP_ENC || i_cmd.op == kwsc_pkg::OP_DEC;
    assign out_free = !r_ovalid || o_out.ready;
    assign o_pop    = r_state == S_IDLE && i_valid && (!is_text || out_free);

    always_comb begin
        place_en  = 1'b0;
        place_idx = i_cmd.idx;
        if (r_state == S_WALK) begin
            place_idx = r_walk;
            place_en  = !r_used[r_walk];
        end else if (o_pop && i_cmd.op == kwsc_pkg::OP_KEY) begin
            place_en = !r_ready && i_cmd.is_letter && !r_used[i_cmd.idx];
        end
    end

    always_comb begin
        n_ochar = i_cmd.ch;
        if (i_cmd.is_letter && r_ready) begin
            if (i_cmd.op == kwsc_pkg::OP_ENC) begin
                n_ochar = kwsc_pkg::CHAR_A + 8'(r_fwd[i_cmd.idx]);
            end else begin
                n_ochar = kwsc_pkg::CHAR_A + 8'(r_inv[i_cmd.idx]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_len    <= '0;
            r_ready  <= 1'b1;
            r_walk   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NL; i++) begin
                r_fwd[i] <= IW'(i);
                r_inv[i] <= IW'(i);
            end
        end else begin
            if (place_en) begin
                if (r_len < IW'(NL)) begin
                    r_fwd[place_idx] <= r_len;
                    r_inv[r_len]     <= place_idx;
                    r_len            <= r_len + 1'b1;
                end
                r_used[place_idx] <= 1'b1;
            end
            if (out_free) begin
                r_ovalid <= o_pop && is_text;
                r_ochar  <= n_ochar;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.op == kwsc_pkg::OP_START) begin
                        r_used  <= '0;
                        r_len   <= '0;
                        r_ready <= 1'b0;
                    end else if (o_pop && i_cmd.op == kwsc_pkg::OP_FINAL && !r_ready) begin
                        r_walk  <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // advance through the alphabet, appending unused letters
                    if (r_walk == IW'(NL - 1)) begin
                        r_ready <= 1'b1;
                        r_walk  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_walk <= r_walk + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.out_char = r_ochar;

    `ASSERT_NEVER(a_walk_when_ready, i_clk, i_rst_n, r_state == S_WALK && r_ready)
    `ASSERT_HOLDS(a_len_tracks_used, i_clk, i_rst_n, int'(r_len) == $countones(r_used))
    `ASSERT_HOLDS(a_walk_fills_all, i_clk, i_rst_n,
        (r_state == S_WALK && r_walk == IW'(NL - 1)) |=> r_len == IW'(NL))
    `ASSERT_NEVER(a_no_pop_in_walk, i_clk, i_rst_n, o_pop && r_state == S_WALK)

endmodule

[design/keyword_substitution_cipher_core.sv]
// Keyword substitution cipher. Requests enter on i_in (opcode plus byte) and
// substituted bytes leave on o_out, one result for each encrypt or decrypt
// request and none for the others. A register stage decodes each request, a
// queue of QUEUE_DEPTH entries carries it to the table engine, and a result
// register drives o_out. Encrypt, decrypt, start and key requests do not hold
// the table engine, so text streams at one byte per cycle while o_out is
// ready. A finalize request holds the table engine while it walks the
// 26 letters, one letter per cycle through the single table write port; the
// front end keeps taking requests until the queue fills. Depends on kwsc_pkg,
// kwsc_in_if, kwsc_out_if, kwsc_front, kwsc_fifo and kwsc_back.
module keyword_substitution_cipher_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kwsc_in_if.sink       i_in,
    kwsc_out_if.source    o_out
);

    logic           push;
    logic           push_ready;
    kwsc_pkg::t_cmd push_cmd;
    logic           pop_valid;
    logic           pop;
    kwsc_pkg::t_cmd pop_cmd;

    kwsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    kwsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    kwsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop_valid),
        .i_cmd   (pop_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[dv/kwsc_cipher_checker.sv]
`timescale 1ns / 100ps
// Checker for the keyword substitution cipher: watches both channels, keeps its
// own cipher tables, and compares every result byte with the predicted one.
// Depends on kwsc_pkg, kwsc_in_if and kwsc_out_if.
module kwsc_cipher_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    kwsc_in_if   i_req,
    kwsc_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    logic [kwsc_pkg::IDX_W-1:0]   plain_to_cipher [kwsc_pkg::LETTERS];
    logic [kwsc_pkg::IDX_W-1:0]   cipher_to_plain [kwsc_pkg::LETTERS];
    logic [kwsc_pkg::LETTERS-1:0] letters_taken;
    logic [kwsc_pkg::IDX_W-1:0]   placed_count;
    logic                         key_complete;
    logic [7:0]                   cipher_bytes_due [$];

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c >= kwsc_pkg::CHAR_LA && c <= kwsc_pkg::CHAR_LZ) return c - kwsc_pkg::CASE_GAP;
        return c;
    endfunction

    function automatic logic is_capital(input logic [7:0] c);
        return c >= kwsc_pkg::CHAR_A && c <= kwsc_pkg::CHAR_Z;
    endfunction

    task automatic append_letter(input int idx);
        if (int'(placed_count) < kwsc_pkg::LETTERS) begin
            plain_to_cipher[idx]          = placed_count;
            cipher_to_plain[placed_count] = kwsc_pkg::IDX_W'(idx);
            placed_count                  = placed_count + 1'b1;
        end
        letters_taken[idx] = 1'b1;
    endtask

    task automatic apply_cipher_request(input logic [2:0] op, input logic [7:0] ch);
        logic [7:0] c;
        int         idx;
        c   = fold_upper(ch);
        idx = int'(c) - int'(kwsc_pkg::CHAR_A);
        case (op)
            kwsc_pkg::OP_START: begin
                letters_taken = '0;
                placed_count  = '0;
                key_complete  = 1'b0;
            end
            kwsc_pkg::OP_KEY: begin
                if (!key_complete && is_capital(c) && !letters_taken[idx])
                    append_letter(idx);
            end
            kwsc_pkg::OP_FINAL: begin
                if (!key_complete) begin
                    for (int i = 0; i < kwsc_pkg::LETTERS; i++)
                        if (!letters_taken[i]) append_letter(i);
                    key_complete = 1'b1;
                end
            end
            kwsc_pkg::OP_ENC: begin
                if (is_capital(c) && key_complete)
                    c = kwsc_pkg::CHAR_A
                        + 8'(int'(plain_to_cipher[idx]) % kwsc_pkg::LETTERS);
                cipher_bytes_due.push_back(c);
            end
            kwsc_pkg::OP_DEC: begin
                c   = ch;
                idx = int'(c) - int'(kwsc_pkg::CHAR_A);
                if (is_capital(c) && key_complete)
                    c = kwsc_pkg::CHAR_A
                        + 8'(int'(cipher_to_plain[idx]) % kwsc_pkg::LETTERS);
                cipher_bytes_due.push_back(c);
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] exp_byte,
                                 input logic [7:0] got_byte);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= 10)
            $display("%0t: %s: expected 8'h%02h, got 8'h%02h", $realtime, what,
                     exp_byte, got_byte);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kwsc_pkg::LETTERS; i++) begin
                plain_to_cipher[i] = kwsc_pkg::IDX_W'(i);
                cipher_to_plain[i] = kwsc_pkg::IDX_W'(i);
            end
            letters_taken = '0;
            placed_count  = '0;
            key_complete  = 1'b1;
            cipher_bytes_due.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                apply_cipher_request(i_req.opcode, i_req.in_char);
            if (i_res.valid && i_res.ready) begin
                if (cipher_bytes_due.size() == 0)
                    note_mismatch("result with no request waiting", 8'h00, i_res.out_char);
                else if (cipher_bytes_due[0] !== i_res.out_char)
                    note_mismatch("out_char mismatch", cipher_bytes_due.pop_front(),
                                  i_res.out_char);
                else
                    void'(cipher_bytes_due.pop_front());
            end
        end
        o_pending = cipher_bytes_due.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Top of the keyword substitution cipher testbench: clock, reset, request and
// result-side stimulus, verdict. Depends on kwsc_pkg, the channel interfaces,
// keyword_substitution_cipher_core and kwsc_cipher_checker.
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int TEXT_ITEMS   = 1200;
    localparam int CALM_TAIL    = 200;

    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    logic clk;
    logic rst_n;
    logic idle_on;
    int   sent_count;
    int   fail_count;
    int   pending;
    int   cycle_count;

    kwsc_in_if  req_ch ();
    kwsc_out_if res_ch ();

    keyword_substitution_cipher_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    kwsc_cipher_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // stall the result side in bursts
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 11) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [7:0] ch);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.opcode  <= op;
        req_ch.in_char <= ch;
        do @(posedge clk); while (!req_ch.ready);
        if (op <= kwsc_pkg::OP_DEC) sent_count++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return kwsc_pkg::CHAR_A + 8'($urandom_range(0, kwsc_pkg::LETTERS - 1));
            2:       return kwsc_pkg::CHAR_LA + 8'($urandom_range(0, kwsc_pkg::LETTERS - 1));
            default: return 8'($urandom_range(8'h20, 8'h7F));
        endcase
    endfunction

    function automatic logic [7:0] pick_key_byte();
        if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        return ($urandom_range(0, 1) ? kwsc_pkg::CHAR_A : kwsc_pkg::CHAR_LA)
               + 8'($urandom_range(0, kwsc_pkg::LETTERS - 1));
    endfunction

    initial begin
        logic [kwsc_pkg::IDX_W-1:0] perm [kwsc_pkg::LETTERS];
        logic [kwsc_pkg::IDX_W-1:0] swap;
        int                         j;

        rst_n          = 1'b0;
        idle_on        = 1'b0;
        sent_count     = 0;
        req_ch.valid   = 1'b0;
        req_ch.opcode  = kwsc_pkg::OP_START;
        req_ch.in_char = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity tables after reset, ignored key traffic while ready
        send_request(kwsc_pkg::OP_ENC, "a");
        send_request(kwsc_pkg::OP_DEC, 8'hFF);
        send_request(kwsc_pkg::OP_ENC, 8'h00);
        send_request(kwsc_pkg::OP_KEY, "Q");
        send_request(kwsc_pkg::OP_FINAL, 8'h00);
        // text before finalize, then restart mid-key
        send_request(kwsc_pkg::OP_START, 8'hFF);
        send_request(kwsc_pkg::OP_KEY, "z");
        send_request(kwsc_pkg::OP_ENC, "b");
        send_request(kwsc_pkg::OP_DEC, "B");
        send_request(kwsc_pkg::OP_START, 8'h00);
        send_request(kwsc_pkg::OP_KEY, "k");
        send_request(kwsc_pkg::OP_KEY, " ");
        send_request(kwsc_pkg::OP_KEY, "E");
        send_request(kwsc_pkg::OP_KEY, "e");
        send_request(kwsc_pkg::OP_KEY, "9");
        send_request(kwsc_pkg::OP_KEY, "y");
        send_request(kwsc_pkg::OP_KEY, 8'hFF);
        send_request(OP_SPARE5, "A");
        send_request(OP_SPARE6, 8'hFF);
        send_request(OP_SPARE7, 8'h00);
        send_request(kwsc_pkg::OP_FINAL, 8'h00);
        send_request(kwsc_pkg::OP_FINAL, 8'hFF);
        send_request(kwsc_pkg::OP_ENC, "Z");
        send_request(kwsc_pkg::OP_ENC, "a");
        send_request(kwsc_pkg::OP_DEC, "A");
        send_request(kwsc_pkg::OP_DEC, "z");
        send_request(kwsc_pkg::OP_ENC, "{");
        send_request(kwsc_pkg::OP_DEC, "@");

        while (sent_count < TEXT_ITEMS) begin
            idle_on = (sent_count < TEXT_ITEMS - CALM_TAIL) ? ($urandom_range(0, 3) != 0) : 1'b0;
            if ($urandom_range(0, 6) != 0) begin
                send_request(kwsc_pkg::OP_START, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0) begin
                    for (int i = 0; i < kwsc_pkg::LETTERS; i++)
                        perm[i] = kwsc_pkg::IDX_W'(i);
                    for (int i = kwsc_pkg::LETTERS - 1; i > 0; i--) begin
                        j       = $urandom_range(0, i);
                        swap    = perm[i];
                        perm[i] = perm[j];
                        perm[j] = swap;
                    end
                    for (int i = 0; i < kwsc_pkg::LETTERS; i++)
                        send_request(kwsc_pkg::OP_KEY,
                                     ($urandom_range(0, 1) ? kwsc_pkg::CHAR_A
                                                           : kwsc_pkg::CHAR_LA)
                                     + 8'(perm[i]));
                end else begin
                    repeat ($urandom_range(0, 20))
                        send_request(kwsc_pkg::OP_KEY, pick_key_byte());
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_request(kwsc_pkg::OP_FINAL, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 5) == 0) send_request(kwsc_pkg::OP_FINAL, 8'h00);
                end
                repeat ($urandom_range(1, 40))
                    send_request($urandom_range(0, 1) ? kwsc_pkg::OP_ENC : kwsc_pkg::OP_DEC,
                                 pick_text_byte());
            end else begin
                repeat ($urandom_range(1, 8))
                    send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
        end
        req_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
